/* sv/grc_pkg.sv */
// Shared types, constants and trigonometry for the grid ray caster.
package grc_pkg;

   // Fixed-point formats.
   localparam int FRAC_BITS = 8;
   localparam int TRIG_BITS = 14;
   localparam int TRIG_MIN  = 16;
   localparam logic [16:0] POS_MAX = 17'h1FFFF;

   // Datapath widths, sized for the largest grid, cell and step count.
   localparam int DW  = 22;      // signed driven delta of one crossing point
   localparam int QW  = 36;      // dividend and quotient width of the divider chain
   localparam int DVW = 27;      // divisor width of the divider chain
   localparam int TW  = DW + 1;  // tag: quotient sign flag and driven delta

   // One beat travelling down the divider chain.
   typedef struct packed {
      logic           valid;
      logic [DVW-1:0] rem;
      logic [QW-1:0]  num;
      logic [QW-1:0]  quo;
      logic [DVW-1:0] div;
      logic [TW-1:0]  tag;
   } div_beat_type;

   localparam logic [14:0] QUARTER_SINE [91] = '{
      15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997,
      15'd2280, 15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964, 15'd4240,
      15'd4516, 15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5872, 15'd6138, 15'd6402,
      15'd6664, 15'd6924, 15'd7182, 15'd7438, 15'd7692, 15'd7943, 15'd8192, 15'd8438,
      15'd8682, 15'd8923, 15'd9162, 15'd9397, 15'd9630, 15'd9860, 15'd10087, 15'd10311,
      15'd10531, 15'd10749, 15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786,
      15'd11982, 15'd12176, 15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085,
      15'd13255, 15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189,
      15'd14330, 15'd14466, 15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082,
      15'd15191, 15'd15296, 15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749,
      15'd15826, 15'd15897, 15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182,
      15'd16225, 15'd16262, 15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374,
      15'd16382, 15'd16384
   };

   // Sine of a whole-degree angle below 360, Q1.14.
   function automatic logic signed [15:0] sine_deg(input logic [8:0] a);
      logic [8:0] r;
      logic signed [15:0] v;
      if (a < 9'd90) begin
         v = signed'({1'b0, QUARTER_SINE[7'(a)]});
      end else if (a < 9'd180) begin
         r = 9'd180 - a;
         v = signed'({1'b0, QUARTER_SINE[7'(r)]});
      end else if (a < 9'd270) begin
         r = a - 9'd180;
         v = -signed'({1'b0, QUARTER_SINE[7'(r)]});
      end else begin
         r = 9'd360 - a;
         v = -signed'({1'b0, QUARTER_SINE[7'(r)]});
      end
      return v;
   endfunction

endpackage

/* sv/grc_div_cell.sv */
// One restoring division step, registered: takes one quotient bit per cell.
module grc_div_cell import grc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  div_beat_type beat_i,
   output div_beat_type beat_o
);

   logic [DVW:0] trial;
   logic         ge;
   div_beat_type beat_in;
   div_beat_type beat_ff;

   always_comb begin
      trial        = {beat_i.rem, beat_i.num[QW-1]};
      ge           = trial >= {1'b0, beat_i.div};
      beat_in      = beat_i;
      beat_in.rem  = ge ? DVW'(trial - {1'b0, beat_i.div}) : trial[DVW-1:0];
      beat_in.num  = {beat_i.num[QW-2:0], 1'b0};
      beat_in.quo  = {beat_i.quo[QW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff <= '0;
      end else begin
         beat_ff <= beat_in;
      end
   end

   assign beat_o = beat_ff;

endmodule

/* sv/grc_div_chain.sv */
// Row of division cells; each beat advances one cell per cycle.
module grc_div_chain import grc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  div_beat_type beat_i,
   output div_beat_type beat_o
);

   div_beat_type link [QW+1];

   assign link[0] = beat_i;

   for (genvar g = 0; g < QW; g++) begin : g_cell
      grc_div_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .beat_i (link[g]),
         .beat_o (link[g+1])
      );
   end

   assign beat_o = link[QW];

endmodule

/* sv/grid_ray_caster.sv */
// Top level of the grid ray caster: sequencer, grid walks and result register.
// The sequencer handles one ray at a time and accepts a new ray only while it is idle.
// Crossing points enter a 36-cell divider chain one per cycle; the wall height takes one more
// pass down it. A new ray is taken while the previous beat still waits in the output register.
// Synchronous active-high reset empties the chain, idles the sequencer and clears wall_map.
module grid_ray_caster import grc_pkg::*; #(
   parameter int GRID_SIDE     = 8,
   parameter int CELL_SHIFT    = 6,
   parameter int MAX_STEPS     = 8,
   parameter int SCREEN_HEIGHT = 320
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [63:0] csr_wall_map,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [16:0] req_player_x,
   input  logic [16:0] req_player_y,
   input  logic [8:0]  req_ray_angle,
   input  logic [5:0]  req_column,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_column_out,
   output logic [16:0] rsp_distance,
   output logic [8:0]  rsp_wall_height,
   output logic [7:0]  rsp_top_row,
   output logic        rsp_vertical_side,
   output logic [16:0] rsp_hit_x,
   output logic [16:0] rsp_hit_y
);

   // Shift from Q9.8 world units to a grid cell index, and one cell in Q9.8.
   localparam int SH    = FRAC_BITS + CELL_SHIFT;
   localparam int CELL  = 1 << SH;
   localparam int NUM   = (1 << CELL_SHIFT) * SCREEN_HEIGHT * (1 << FRAC_BITS);
   localparam int NSTEP = 2 * MAX_STEPS;
   localparam int CNW   = $clog2(NSTEP);
   localparam int SW    = QW + 1;          // signed crossing offsets
   localparam int CW    = QW + 2;          // signed crossing coordinates
   localparam int PW    = 16 + SW;         // trig times offset
   localparam int DLW   = PW + 1 - TRIG_BITS;
   localparam int HW    = $clog2(SCREEN_HEIGHT + 1);

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_ISSUE   = 9'b000000010,
      ST_COLLECT = 9'b000000100,
      ST_MULV    = 9'b000001000,
      ST_MULH    = 9'b000010000,
      ST_SUBH    = 9'b000100000,
      ST_HDIV    = 9'b001000000,
      ST_HWAIT   = 9'b010000000,
      ST_FIN     = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic [63:0] wall_map_ff;

   // Per-ray registers.
   logic [16:0]        px_ff, py_ff;
   logic [5:0]         col_ff;
   logic signed [15:0] s_ff, c_ff;
   logic               ven_ff, hen_ff;
   logic signed [DW-1:0] vcur_ff, hcur_ff;
   logic               vneg_ff, hneg_ff;
   logic [CNW-1:0]     iss_cnt_ff, res_cnt_ff;

   // Walk hits.
   logic               vhit_ff, hhit_ff;
   logic signed [SW-1:0] vdx_ff, vdy_ff, hdx_ff, hdy_ff;
   logic signed [PW-1:0] pa_ff, pb_ff;
   logic [DLW-1:0]     vd_ff, hd_ff;

   // Chosen hit.
   logic               hit_ff, vsel_ff;
   logic [DLW-1:0]     dsel_ff;
   logic signed [SW-1:0] sdx_ff, sdy_ff;
   logic [HW-1:0]      height_ff;

   div_beat_type iss_ff, iss_in, chain_out;

   // Output register.
   logic        rsp_valid_ff;
   logic [5:0]  column_out_ff;
   logic [16:0] distance_ff, hit_x_ff, hit_y_ff;
   logic [8:0]  wall_height_ff;
   logic [7:0]  top_row_ff;
   logic        vertical_side_ff;

   // Accept-time decode of the ray direction.
   logic [8:0]         ang, cang;
   logic [9:0]         cang_w;
   logic signed [15:0] s_new, c_new;
   logic signed [DW-1:0] frac_x, frac_y;

   // Issue datapath.
   logic               iss_vert;
   logic signed [DW-1:0] iss_delta;
   logic signed [15:0] iss_mop, iss_dop;
   logic signed [DW+15:0] iss_prod;
   logic [DW+15:0]     iss_pmag;
   logic [15:0]        iss_dmag;

   // Collect datapath.
   logic               col_vert, col_wall;
   logic [QW-1:0]      col_q;
   logic signed [SW-1:0] col_other, col_delta, col_dx, col_dy;
   logic signed [CW-1:0] col_x, col_y;
   logic [CW-1:0]      mx, my;
   logic [5:0]         cidx;

   // Finish datapath.
   logic signed [PW:0] diff;
   logic [DLW-1:0]     dist_new;
   logic               pick_v, pick_hit;
   logic [DLW-1:0]     pick_d;
   logic [HW-1:0]      height_new;
   logic signed [CW-1:0] rx, ry;
   logic               fin_go;

   function automatic logic [16:0] clamp_pos(input logic signed [CW-1:0] v);
      logic [16:0] r;
      if (v[CW-1]) begin
         r = '0;
      end else if (v > CW'(POS_MAX)) begin
         r = POS_MAX;
      end else begin
         r = v[16:0];
      end
      return r;
   endfunction

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);

   // Direction decode. Angles past 359 wrap once.
   always_comb begin
      ang    = (req_ray_angle > 9'd359) ? 9'(req_ray_angle - 9'd360) : req_ray_angle;
      cang_w = 10'(ang) + 10'd90;
      cang   = (cang_w >= 10'd360) ? 9'(cang_w - 10'd360) : cang_w[8:0];
      s_new  = sine_deg(ang);
      c_new  = sine_deg(cang);
      frac_x = DW'(req_player_x & 17'((CELL - 1) & 32'h1FFFF));
      frac_y = DW'(req_player_y & 17'((CELL - 1) & 32'h1FFFF));
   end

   // Crossing points are issued vertical walk first. Each product gets a register
   // before it enters the divider chain.
   always_comb begin
      iss_vert  = iss_cnt_ff < CNW'(MAX_STEPS);
      iss_delta = iss_vert ? vcur_ff : hcur_ff;
      iss_mop   = iss_vert ? s_ff : c_ff;
      iss_dop   = iss_vert ? c_ff : s_ff;
      iss_prod  = iss_delta * iss_mop;
      iss_pmag  = iss_prod[DW+15] ? (DW+16)'(-iss_prod) : iss_prod;
      iss_dmag  = iss_dop[15] ? 16'(-iss_dop) : iss_dop;
      iss_in    = '0;
      if (state_ff == ST_ISSUE) begin
         iss_in.valid = 1'b1;
         iss_in.num   = QW'(iss_pmag);
         iss_in.div   = DVW'(iss_dmag);
         iss_in.tag   = {iss_prod[DW+15] ^ iss_dop[15], iss_delta};
      end else if (state_ff == ST_HDIV) begin
         iss_in.valid = 1'b1;
         iss_in.num   = QW'(NUM);
         iss_in.div   = (pick_d > DLW'(NUM)) ? DVW'(NUM + 1) : DVW'(pick_d);
      end
   end

   grc_div_chain u_chain (
      .clock  (clock),
      .reset  (reset),
      .beat_i (iss_ff),
      .beat_o (chain_out)
   );

   // Quotients come back in issue order. The tag tells the sign of the offset; the
   // result count tells which walk it belongs to.
   always_comb begin
      col_vert  = res_cnt_ff < CNW'(MAX_STEPS);
      col_q     = chain_out.quo;
      col_delta = SW'(signed'(chain_out.tag[DW-1:0]));
      col_other = chain_out.tag[DW] ? signed'({1'b0, col_q}) : -signed'({1'b0, col_q});
      col_dx    = col_vert ? col_delta : col_other;
      col_dy    = col_vert ? col_other : col_delta;
      col_x     = signed'(CW'(px_ff)) + CW'(col_dx);
      col_y     = signed'(CW'(py_ff)) + CW'(col_dy);
      mx        = col_x >> SH;
      my        = col_y >> SH;
      cidx      = 6'(my * GRID_SIDE + mx);
      // Negative, outside the grid, or the corner cell never counts as a wall.
      col_wall  = !col_x[CW-1] && !col_y[CW-1] && (mx < CW'(GRID_SIDE)) &&
                  (my < CW'(GRID_SIDE)) && (cidx != 6'd0) && wall_map_ff[cidx];
   end

   // Projected distance c*dx - s*dy, floored at zero and scaled back to Q9.8.
   always_comb begin
      diff     = (PW+1)'(pa_ff) - (PW+1)'(pb_ff);
      dist_new = diff[PW] ? '0 : DLW'(diff[PW:TRIG_BITS]);
      // On a tie the horizontal hit wins.
      pick_v   = vhit_ff && (!hhit_ff || (vd_ff < hd_ff));
      pick_hit = vhit_ff || hhit_ff;
      pick_d   = pick_v ? vd_ff : hd_ff;
      height_new = !hit_ff ? '0 :
                   (chain_out.quo > QW'(SCREEN_HEIGHT)) ? HW'(SCREEN_HEIGHT) :
                   HW'(chain_out.quo);
      rx       = hit_ff ? signed'(CW'(px_ff)) + CW'(sdx_ff) : signed'(CW'(px_ff));
      ry       = hit_ff ? signed'(CW'(py_ff)) + CW'(sdy_ff) : signed'(CW'(py_ff));
      fin_go   = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ready);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (iss_cnt_ff == CNW'(NSTEP - 1)) begin
               state_in = ST_COLLECT;
            end
         end
         ST_COLLECT: begin
            if (chain_out.valid && (res_cnt_ff == CNW'(NSTEP - 1))) begin
               state_in = ST_MULV;
            end
         end
         ST_MULV:  state_in = ST_MULH;
         ST_MULH:  state_in = ST_SUBH;
         ST_SUBH:  state_in = ST_HDIV;
         ST_HDIV:  state_in = ST_HWAIT;
         ST_HWAIT: begin
            if (chain_out.valid) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (fin_go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wall_map_ff  <= '0;
         iss_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         iss_cnt_ff   <= '0;
         res_cnt_ff   <= '0;
         vhit_ff      <= 1'b0;
         hhit_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;
         iss_ff   <= iss_in;
         if (csr_valid) begin
            wall_map_ff <= csr_wall_map;
         end
         if (fin_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_IDLE) begin
            iss_cnt_ff <= '0;
            res_cnt_ff <= '0;
            vhit_ff    <= 1'b0;
            hhit_ff    <= 1'b0;
         end
         if (state_ff == ST_ISSUE) begin
            iss_cnt_ff <= iss_cnt_ff + 1'b1;
         end
         if ((state_ff == ST_COLLECT) && chain_out.valid) begin
            res_cnt_ff <= res_cnt_ff + 1'b1;
            if (col_vert && ven_ff && !vhit_ff && col_wall) begin
               vhit_ff <= 1'b1;
            end
            if (!col_vert && hen_ff && !hhit_ff && col_wall) begin
               hhit_ff <= 1'b1;
            end
         end
      end
   end

   // Ray payload.
   always_ff @(posedge clock) begin
      if ((state_ff == ST_IDLE) && req_valid) begin
         px_ff  <= req_player_x;
         py_ff  <= req_player_y;
         col_ff <= req_column;
         s_ff   <= s_new;
         c_ff   <= c_new;
         ven_ff <= (c_new > 16'(TRIG_MIN)) || (c_new < -16'(TRIG_MIN));
         hen_ff <= (s_new > 16'(TRIG_MIN)) || (s_new < -16'(TRIG_MIN));
         // Walks looking right or down start at the next cell edge, the others
         // one LSB before the current cell edge.
         vneg_ff <= !(c_new > 16'(TRIG_MIN));
         hneg_ff <= !(s_new < -16'(TRIG_MIN));
         vcur_ff <= (c_new > 16'(TRIG_MIN)) ? DW'(CELL) - frac_x : -frac_x - DW'(1);
         hcur_ff <= (s_new < -16'(TRIG_MIN)) ? DW'(CELL) - frac_y : -frac_y - DW'(1);
      end else if (state_ff == ST_ISSUE) begin
         if (iss_vert) begin
            vcur_ff <= vneg_ff ? vcur_ff - DW'(CELL) : vcur_ff + DW'(CELL);
         end else begin
            hcur_ff <= hneg_ff ? hcur_ff - DW'(CELL) : hcur_ff + DW'(CELL);
         end
      end
      if ((state_ff == ST_COLLECT) && chain_out.valid) begin
         if (col_vert && ven_ff && !vhit_ff && col_wall) begin
            vdx_ff <= col_dx;
            vdy_ff <= col_dy;
         end
         if (!col_vert && hen_ff && !hhit_ff && col_wall) begin
            hdx_ff <= col_dx;
            hdy_ff <= col_dy;
         end
      end
      case (state_ff)
         ST_MULV: begin
            pa_ff <= c_ff * vdx_ff;
            pb_ff <= s_ff * vdy_ff;
         end
         ST_MULH: begin
            vd_ff <= dist_new;
            pa_ff <= c_ff * hdx_ff;
            pb_ff <= s_ff * hdy_ff;
         end
         ST_SUBH: begin
            hd_ff <= dist_new;
         end
         ST_HDIV: begin
            hit_ff  <= pick_hit;
            vsel_ff <= pick_v;
            dsel_ff <= pick_d;
            sdx_ff  <= pick_v ? vdx_ff : hdx_ff;
            sdy_ff  <= pick_v ? vdy_ff : hdy_ff;
         end
         ST_HWAIT: begin
            if (chain_out.valid) begin
               height_ff <= height_new;
            end
         end
         default: begin
         end
      endcase
   end

   // Output register; the next ray may already be running while this beat waits.
   always_ff @(posedge clock) begin
      if (fin_go) begin
         column_out_ff    <= col_ff;
         distance_ff      <= !hit_ff ? POS_MAX :
                             (|dsel_ff[DLW-1:17]) ? POS_MAX : dsel_ff[16:0];
         wall_height_ff   <= 9'(height_ff);
         top_row_ff       <= 8'(HW'(SCREEN_HEIGHT / 2) - (height_ff >> 1));
         vertical_side_ff <= hit_ff && vsel_ff;
         hit_x_ff         <= clamp_pos(rx);
         hit_y_ff         <= clamp_pos(ry);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_column_out    = column_out_ff;
   assign rsp_distance      = distance_ff;
   assign rsp_wall_height   = wall_height_ff;
   assign rsp_top_row       = top_row_ff;
   assign rsp_vertical_side = vertical_side_ff;
   assign rsp_hit_x         = hit_x_ff;
   assign rsp_hit_y         = hit_y_ff;

   // The chain only returns beats while the sequencer waits for them.
   a_chain_expected: assert property (@(posedge clock) disable iff (reset)
      chain_out.valid |-> (state_ff == ST_COLLECT) || (state_ff == ST_HWAIT))
      else $error("divider beat arrived outside a collect phase");

   // Every issue cycle puts a beat into the chain.
   a_issue_beat: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ISSUE) |=> iss_ff.valid)
      else $error("issue cycle did not launch a divider beat");

   // Height never exceeds the screen.
   a_height_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN) |-> (height_ff <= HW'(SCREEN_HEIGHT)))
      else $error("wall height above screen height");

   // A ray that hits nothing reports the saturated distance.
   a_miss_dist: assert property (@(posedge clock) disable iff (reset)
      fin_go && !hit_ff |=> (rsp_distance == POS_MAX) && (rsp_wall_height == 9'd0))
      else $error("missed ray without saturated distance");

endmodule

/* dv/tb_grid_ray_caster.sv */
// Self-checking testbench for the grid ray caster: directed and random rays against a built-in predictor.
module tb_grid_ray_caster;
   import grc_pkg::*;

   localparam int GRID_SIDE     = 8;
   localparam int CELL_SHIFT    = 6;
   localparam int MAX_STEPS     = 8;
   localparam int SCREEN_HEIGHT = 320;
   localparam int RANDOM_RAYS   = 1478;
   localparam int DRAIN_CYCLES  = 200;
   localparam int IDLE_LIMIT    = 4000;

   // One ray request as it is driven onto the request channel.
   typedef struct packed {
      logic [16:0] player_x;
      logic [16:0] player_y;
      logic [8:0]  ray_angle;
      logic [5:0]  column;
   } ray_type;

   // One column slice as the block should return it.
   typedef struct packed {
      logic [5:0]  column_out;
      logic [16:0] distance;
      logic [8:0]  wall_height;
      logic [7:0]  top_row;
      logic        vertical_side;
      logic [16:0] hit_x;
      logic [16:0] hit_y;
   } slice_type;

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [63:0] csr_wall_map;
   logic        req_valid;
   logic        req_ready;
   logic [16:0] req_player_x;
   logic [16:0] req_player_y;
   logic [8:0]  req_ray_angle;
   logic [5:0]  req_column;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [5:0]  rsp_column_out;
   logic [16:0] rsp_distance;
   logic [8:0]  rsp_wall_height;
   logic [7:0]  rsp_top_row;
   logic        rsp_vertical_side;
   logic [16:0] rsp_hit_x;
   logic [16:0] rsp_hit_y;

   grid_ray_caster #(
      .GRID_SIDE(GRID_SIDE), .CELL_SHIFT(CELL_SHIFT),
      .MAX_STEPS(MAX_STEPS), .SCREEN_HEIGHT(SCREEN_HEIGHT)
   ) u_dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wall_map(csr_wall_map),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_player_x(req_player_x), .req_player_y(req_player_y),
      .req_ray_angle(req_ray_angle), .req_column(req_column),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_column_out(rsp_column_out), .rsp_distance(rsp_distance),
      .rsp_wall_height(rsp_wall_height), .rsp_top_row(rsp_top_row),
      .rsp_vertical_side(rsp_vertical_side),
      .rsp_hit_x(rsp_hit_x), .rsp_hit_y(rsp_hit_y)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Rays waiting to be driven, and slices still owed by the block.
   ray_type   pending_rays[$];
   slice_type owed_slices[$];
   logic [63:0] grid_walls;      // the predictor's copy of the wall map
   int        error_count = 0;
   int        idle_cycles;
   bit        feed_hold;         // when set the driver offers nothing
   int        burst_left;
   int        gap_left;
   int        stall_phase;

   // Sine in Q1.14 for a whole-degree angle below 360, from the quarter table.
   function automatic longint table_sine(input int a);
      int r;
      r = a % 90;
      case (a / 90)
         0: table_sine = QUARTER_SINE[r];
         1: table_sine = QUARTER_SINE[90 - r];
         2: table_sine = -longint'(QUARTER_SINE[r]);
         default: table_sine = -longint'(QUARTER_SINE[90 - r]);
      endcase
   endfunction

   // Wall test at a Q9.8 point; out-of-grid points and cell zero never hit.
   function automatic bit wall_at(input longint x, input longint y);
      longint mx, my, idx;
      if (x < 0 || y < 0) return 1'b0;
      mx = x >>> (FRAC_BITS + CELL_SHIFT);
      my = y >>> (FRAC_BITS + CELL_SHIFT);
      if (mx >= GRID_SIDE || my >= GRID_SIDE) return 1'b0;
      idx = my * GRID_SIDE + mx;
      if (idx <= 0 || idx > 63) return 1'b0;
      return grid_walls[idx];
   endfunction

   // Walk across vertical (vert=1) or horizontal grid lines until the first wall.
   function automatic bit grid_walk(input longint px, input longint py, input longint s,
                                    input longint c, input bit vert, output longint hx,
                                    output longint hy, output longint dist_q);
      longint sh, cell_size, drive, base, start, stride, dx, dy, d;
      sh = FRAC_BITS + CELL_SHIFT;
      cell_size = longint'(1) << sh;
      drive = vert ? c : -s;
      base = vert ? px : py;
      hx = 0; hy = 0; dist_q = 0;
      if (drive > TRIG_MIN) begin
         start = ((base >>> sh) << sh) + cell_size;
         stride = cell_size;
      end else if (drive < -TRIG_MIN) begin
         start = ((base >>> sh) << sh) - 1;
         stride = -cell_size;
      end else begin
         return 1'b0;
      end
      for (int i = 0; i < MAX_STEPS; i++) begin
         // SystemVerilog signed division truncates toward zero, as required.
         if (vert) begin
            dx = start + i * stride - px;
            dy = -(dx * s) / c;
         end else begin
            dy = start + i * stride - py;
            dx = -(dy * c) / s;
         end
         if (wall_at(px + dx, py + dy)) begin
            d = c * dx - s * dy;
            if (d < 0) d = 0;
            dist_q = d >>> TRIG_BITS;
            hx = px + dx;
            hy = py + dy;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic logic [16:0] clamp_q98(input longint v);
      if (v < 0) return 17'd0;
      if (v > POS_MAX) return POS_MAX;
      return v[16:0];
   endfunction

   // Predict the slice for one ray.
   function automatic slice_type cast_ray(input ray_type ray);
      slice_type sl;
      longint px, py, s, c, vx, vy, vd, hx, hy, hd, rx, ry, d, h;
      int ang;
      bit vhit, hhit, hit, vside;
      px = ray.player_x;
      py = ray.player_y;
      ang = ray.ray_angle;
      if (ang > 359) ang -= 360;
      s = table_sine(ang);
      c = table_sine((ang + 90) % 360);
      vhit = grid_walk(px, py, s, c, 1'b1, vx, vy, vd);
      hhit = grid_walk(px, py, s, c, 1'b0, hx, hy, hd);
      hit = 1'b0; vside = 1'b0; rx = px; ry = py; d = 0; h = 0;
      // The horizontal hit wins a tie.
      if (vhit && (!hhit || vd < hd)) begin
         hit = 1'b1; vside = 1'b1; rx = vx; ry = vy; d = vd;
      end else if (hhit) begin
         hit = 1'b1; rx = hx; ry = hy; d = hd;
      end
      if (hit) begin
         h = (d == 0) ? SCREEN_HEIGHT
                      : ((longint'(1) << CELL_SHIFT) * SCREEN_HEIGHT * 256) / d;
         if (h > SCREEN_HEIGHT) h = SCREEN_HEIGHT;
      end
      sl.column_out    = ray.column;
      sl.distance      = hit ? clamp_q98(d) : POS_MAX;
      sl.wall_height   = h[8:0];
      sl.top_row       = 8'(SCREEN_HEIGHT / 2 - (h >> 1));
      sl.vertical_side = vside;
      sl.hit_x         = clamp_q98(rx);
      sl.hit_y         = clamp_q98(ry);
      return sl;
   endfunction

   // Mostly positions inside the 8x8 grid (512 units), sometimes anywhere in 17 bits.
   function automatic ray_type random_ray();
      ray_type r;
      if ($urandom_range(0, 9) == 0) begin
         r.player_x = 17'($urandom);
         r.player_y = 17'($urandom);
      end else begin
         r.player_x = 17'($urandom_range(0, 512 * 256 - 1));
         r.player_y = 17'($urandom_range(0, 512 * 256 - 1));
      end
      // Angles above 359 are legal on the 9-bit port and wrap around.
      r.ray_angle = ($urandom_range(0, 15) == 0) ? 9'($urandom) : 9'($urandom_range(0, 359));
      r.column = 6'($urandom_range(0, 59));
      return r;
   endfunction

   function automatic ray_type make_ray(input int x, input int y, input int a, input int col);
      ray_type r;
      r.player_x = 17'(x);
      r.player_y = 17'(y);
      r.ray_angle = 9'(a);
      r.column = 6'(col);
      return r;
   endfunction

   // The driver: bursts of rays with random gaps, payload held until accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_player_x <= '0;
         req_player_y <= '0;
         req_ray_angle <= '0;
         req_column <= '0;
         burst_left <= 0;
         gap_left <= 0;
      end else if (!req_valid || req_ready) begin
         if (req_valid && req_ready) void'(pending_rays.pop_front());
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (feed_hold || pending_rays.size() <= (req_valid && req_ready ? 0 : 0)
                      || pending_rays.size() == 0) begin
            req_valid <= 1'b0;
         end else begin
            req_valid <= 1'b1;
            req_player_x <= pending_rays[0].player_x;
            req_player_y <= pending_rays[0].player_y;
            req_ray_angle <= pending_rays[0].ray_angle;
            req_column <= pending_rays[0].column;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // Predict at acceptance, so the owed queue keeps the block's order.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         owed_slices.push_back(cast_ray('{req_player_x, req_player_y, req_ray_angle,
                                          req_column}));
   end

   // The receiver stalls on a rotating pattern: long open stretches, then choppy ones.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_phase <= 0;
      end else begin
         stall_phase <= (stall_phase + 1) % 600;
         if (stall_phase < 200) rsp_ready <= 1'b1;
         else if (stall_phase < 400) rsp_ready <= ($urandom_range(0, 3) != 0);
         else rsp_ready <= ($urandom_range(0, 4) == 0);
      end
   end

   // The monitor: every accepted slice is checked field by field against the oldest one owed.
   always @(posedge clock) begin
      slice_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (owed_slices.size() == 0) begin
            $error("slice for column %0d arrived with none owed", rsp_column_out);
            error_count++;
         end else begin
            want = owed_slices.pop_front();
            if (rsp_column_out !== want.column_out) begin
               $error("column_out: expected %0d, got %0d", want.column_out, rsp_column_out);
               error_count++;
            end
            if (rsp_distance !== want.distance) begin
               $error("distance: expected %0d, got %0d", want.distance, rsp_distance);
               error_count++;
            end
            if (rsp_wall_height !== want.wall_height) begin
               $error("wall_height: expected %0d, got %0d", want.wall_height,
                      rsp_wall_height);
               error_count++;
            end
            if (rsp_top_row !== want.top_row) begin
               $error("top_row: expected %0d, got %0d", want.top_row, rsp_top_row);
               error_count++;
            end
            if (rsp_vertical_side !== want.vertical_side) begin
               $error("vertical_side: expected %0d, got %0d", want.vertical_side,
                      rsp_vertical_side);
               error_count++;
            end
            if (rsp_hit_x !== want.hit_x) begin
               $error("hit_x: expected %0d, got %0d", want.hit_x, rsp_hit_x);
               error_count++;
            end
            if (rsp_hit_y !== want.hit_y) begin
               $error("hit_y: expected %0d, got %0d", want.hit_y, rsp_hit_y);
               error_count++;
            end
         end
      end
   end

   // The watchdog ends the run when no beat moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // Wait until the block has returned everything and the driver has run dry.
   task automatic wait_drained();
      while (pending_rays.size() != 0 || req_valid || owed_slices.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write the wall map while the block is idle; the predictor follows on acceptance.
   task automatic load_walls(input logic [63:0] walls);
      csr_valid <= 1'b1;
      csr_wall_map <= walls;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      grid_walls = walls;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Random rays in one phase, with a single full pause part way through.
   task automatic random_phase(input int count);
      for (int i = 0; i < count; i++) begin
         pending_rays.push_back(random_ray());
         if (i == count / 2) begin
            wait_drained();
         end
         while (pending_rays.size() > 8) @(posedge clock);
      end
      wait_drained();
   endtask

   // A closed box of walls around the border plus a 2x2 block of inner walls.
   localparam logic [63:0] BOX_WALLS = 64'hFF81_8199_9981_81FF;

   initial begin
      logic [63:0] walls [5];
      feed_hold = 1'b0;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_wall_map = '0;
      grid_walls = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty map after reset: nothing can be hit.
      pending_rays.push_back(make_ray(100 * 256, 100 * 256, 45, 0));
      pending_rays.push_back(make_ray(131071, 131071, 359, 59));
      wait_drained();

      load_walls(BOX_WALLS);
      // Directed rays, most from the middle of the box: axis angles where one walk is skipped,
      // diagonals, wrapped angles, corners of the position range, and cell zero.
      pending_rays.push_back(make_ray(256 * 256, 256 * 256, 0, 1));
      pending_rays.push_back(make_ray(256 * 256, 256 * 256, 90, 2));
      pending_rays.push_back(make_ray(256 * 256, 256 * 256, 180, 3));
      pending_rays.push_back(make_ray(256 * 256, 256 * 256, 270, 4));
      pending_rays.push_back(make_ray(256 * 256, 256 * 256, 45, 5));
      pending_rays.push_back(make_ray(256 * 256, 256 * 256, 135, 6));
      pending_rays.push_back(make_ray(256 * 256, 256 * 256, 225, 7));
      pending_rays.push_back(make_ray(256 * 256, 256 * 256, 315, 8));
      pending_rays.push_back(make_ray(256 * 256, 256 * 256, 360, 9));
      pending_rays.push_back(make_ray(256 * 256, 256 * 256, 511, 10));
      pending_rays.push_back(make_ray(0, 0, 315, 11));
      pending_rays.push_back(make_ray(0, 0, 45, 12));
      pending_rays.push_back(make_ray(131071, 131071, 135, 13));
      pending_rays.push_back(make_ray(65 * 256, 65 * 256, 1, 14));
      pending_rays.push_back(make_ray(65 * 256 + 1, 64 * 256 + 5, 179, 15));
      pending_rays.push_back(make_ray(64 * 256, 100 * 256, 89, 16));
      pending_rays.push_back(make_ray(20 * 256, 20 * 256, 225, 17));
      pending_rays.push_back(make_ray(70 * 256, 66 * 256, 180, 59));
      wait_drained();

      // Several wall maps, the extremes among them; the all-ones map includes cell zero.
      walls[0] = 64'hFFFF_FFFF_FFFF_FFFF;
      walls[1] = 64'h0000_0000_0000_0001;
      walls[2] = BOX_WALLS;
      walls[3] = {$urandom, $urandom};
      walls[4] = {$urandom, $urandom} | BOX_WALLS;
      for (int p = 0; p < 5; p++) begin
         load_walls(walls[p]);
         random_phase((p == 2 || p == 4) ? RANDOM_RAYS * 3 / 10 : RANDOM_RAYS / 10);
      end

      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* sim.f */
sv/grc_pkg.sv
sv/grc_div_cell.sv
sv/grc_div_chain.sv
sv/grid_ray_caster.sv
dv/tb_grid_ray_caster.sv
